// ===== hw/rtl/pmt_pkg.sv =====
// Package for the PS/2 mouse packet tracker: widths, reset values, register
// indexes and the packet phase type.
// No dependencies; every other file of the block imports it.
package pmt_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned POS_W       = 12;
	localparam int unsigned BUTTON_W    = 3;
	localparam int unsigned CFG_INDEX_W = 2;

	// Header bit positions.
	localparam int unsigned SYNC_BIT   = 3;
	localparam int unsigned X_SIGN_BIT = 4;
	localparam int unsigned Y_SIGN_BIT = 5;

	localparam logic [POS_W-1:0] MAX_X_RESET = 12'd320;
	localparam logic [POS_W-1:0] MAX_Y_RESET = 12'd200;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAX_X = 2'd0,
		REG_MAX_Y = 2'd1
	} cfg_reg_t;

	// Position of the next byte within a packet.
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_XBYTE  = 2'd1,
		PH_YBYTE  = 2'd2
	} byte_phase_t;

endpackage

// ===== hw/rtl/pmt_stream_if.sv =====
// Handshake channels of the PS/2 mouse packet tracker: the received byte
// stream and the position results. Depends on pmt_pkg.
interface pmt_byte_if
	import pmt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmt_pos_if
	import pmt_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [POS_W-1:0]    pos_x;
	logic [POS_W-1:0]    pos_y;
	logic [BUTTON_W-1:0] button_bits;

	modport source (output valid, output pos_x, output pos_y, output button_bits, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input button_bits, output ready);
endinterface

// ===== hw/rtl/ps2_mouse_packet_tracker.sv =====
// PS/2 mouse packet tracker top level: input register, packet assembly,
// position update with clamping, and the result register.
// Depends on pmt_pkg and the channel interfaces in pmt_stream_if.sv.

// The block takes one mouse byte per request and gathers three bytes into a
// packet. On the third byte with the header sync bit set, it latches the
// buttons, adds the signed X delta to the position, subtracts the Y delta,
// clamps both to 0..max and sends one result; with the sync bit clear the
// packet is dropped and no result is sent. A byte is taken every cycle while
// no waiting result holds the flow: it lands in an input register and is then
// processed by a single add and compare per axis into the result register, so
// a result is registered as its third byte leaves the input register. Only a
// result that is still waiting to be taken holds back the next packet-ending
// byte with the sync bit set. Configuration writes must be done while no
// packet is in flight.
module ps2_mouse_packet_tracker
	import pmt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [POS_W-1:0]       wr_data,
	pmt_byte_if.sink               rx_stream,
	pmt_pos_if.source              pointer
);

	localparam int unsigned SUM_W = POS_W + 2;

	logic [POS_W-1:0]    max_x_q, max_y_q;
	logic [POS_W-1:0]    position_x_q, position_y_q;
	logic [BUTTON_W-1:0] held_buttons_q;
	logic [BYTE_W-1:0]   header_q, xbyte_q;
	byte_phase_t         phase_q;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;

	logic                out_valid_q;
	logic [POS_W-1:0]    out_x_q, out_y_q;
	logic [BUTTON_W-1:0] out_buttons_q;

	logic                in_accept, produces, advance_s1, out_load;
	logic signed [SUM_W-1:0] dx, dy, sum_x, sum_y;
	logic [POS_W-1:0]    next_x, next_y;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RESET;
			max_y_q <= MAX_Y_RESET;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_MAX_X: max_x_q <= wr_data;
				REG_MAX_Y: max_y_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Control of the input register: it moves on unless it holds a
	// packet-ending byte whose result cannot be placed yet.
	assign produces   = (phase_q == PH_YBYTE) && header_q[SYNC_BIT];
	assign advance_s1 = valid_s1 && (!produces || !out_valid_q || pointer.ready);
	assign out_load   = advance_s1 && produces;
	assign rx_stream.ready = !valid_s1 || advance_s1;
	assign in_accept  = rx_stream.valid && rx_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_stream.ready) begin
			valid_s1 <= rx_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= rx_stream.rx_byte;
		end
	end

	// Signed deltas and the clamped next position.
	always_comb begin
		dx    = {{(SUM_W-BYTE_W-1){header_q[X_SIGN_BIT]}}, header_q[X_SIGN_BIT], xbyte_q};
		dy    = {{(SUM_W-BYTE_W-1){header_q[Y_SIGN_BIT]}}, header_q[Y_SIGN_BIT], byte_s1};
		sum_x = signed'({2'b00, position_x_q}) + dx;
		sum_y = signed'({2'b00, position_y_q}) - dy;
		if (sum_x < 0) begin
			next_x = '0;
		end else if (sum_x > signed'({2'b00, max_x_q})) begin
			next_x = max_x_q;
		end else begin
			next_x = sum_x[POS_W-1:0];
		end
		if (sum_y < 0) begin
			next_y = '0;
		end else if (sum_y > signed'({2'b00, max_y_q})) begin
			next_y = max_y_q;
		end else begin
			next_y = sum_y[POS_W-1:0];
		end
	end

	// Packet phase and tracked state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			position_x_q   <= '0;
			position_y_q   <= '0;
			held_buttons_q <= '0;
		end else if (advance_s1) begin
			case (phase_q)
				PH_HEADER: phase_q <= PH_XBYTE;
				PH_XBYTE:  phase_q <= PH_YBYTE;
				default:   phase_q <= PH_HEADER;
			endcase
			if (out_load) begin
				position_x_q   <= next_x;
				position_y_q   <= next_y;
				held_buttons_q <= header_q[BUTTON_W-1:0];
			end
		end
	end

	// Header and X byte storage.
	always_ff @(posedge clk) begin
		if (advance_s1 && phase_q == PH_HEADER) begin
			header_q <= byte_s1;
		end
		if (advance_s1 && phase_q == PH_XBYTE) begin
			xbyte_q <= byte_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pointer.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q       <= next_x;
			out_y_q       <= next_y;
			out_buttons_q <= header_q[BUTTON_W-1:0];
		end
	end

	assign pointer.valid       = out_valid_q;
	assign pointer.pos_x       = out_x_q;
	assign pointer.pos_y       = out_y_q;
	assign pointer.button_bits = out_buttons_q;

	// A new result is only loaded at the third byte of a packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> phase_q == PH_YBYTE)
		else $error("result loaded outside the third byte of a packet");

	// After a result is loaded the next packet starts from its header.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (phase_q == PH_HEADER && out_valid_q))
		else $error("phase or result valid wrong after a packet");

	// Buttons change only with a loaded result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_load |=> $stable(held_buttons_q))
		else $error("buttons changed without a result");

	// The input side stalls only behind a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!rx_stream.ready |-> (valid_s1 && produces && out_valid_q))
		else $error("input stalled without a waiting result");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the PS/2 mouse packet tracker: directed packets, then random
// packets under several clamp limits, checked against a predictor kept in step with the DUT.
// Depends on pmt_pkg, the channel interfaces in pmt_stream_if.sv and the tracker RTL.
module tb_top;
	import pmt_pkg::*;

	localparam int unsigned LIMIT_CYCLES    = 400000;
	localparam int unsigned HOLD_OFF_CYCLES = 600;
	localparam int unsigned DRAIN_CYCLES    = 6;
	localparam int unsigned PHASE_BYTES     = 190;

	// Register indexes past the end of the list; writes there are dropped.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]    x;
		logic [POS_W-1:0]    y;
		logic [BUTTON_W-1:0] btn;
	} pointer_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              typed;
		pointer_t          want;
	} stim_row_t;

	// Directed packets. A typed row carries the result its byte must produce; the others
	// are left to the predictor.
	localparam stim_row_t DIRECTED [24] = '{
		// Sync set, no motion, from reset.
		'{8'h08, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b1, '{12'd0, 12'd0, 3'd0}},
		// All buttons, largest positive X step.
		'{8'h0F, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b1, '{12'd255, 12'd0, 3'd7}},
		// X and Y both past their reset limits.
		'{8'h28, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b1, '{12'd320, 12'd200, 3'd0}},
		// Largest negative steps on both axes.
		'{8'h38, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		// Both axes pushed below zero.
		'{8'h18, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'hFF, 1'b1, '{12'd0, 12'd0, 3'd0}},
		// Sync bit clear: the packet is dropped.
		'{8'h07, 1'b0, '0}, '{8'h7F, 1'b0, '0}, '{8'h7F, 1'b0, '0},
		// Overflow bits set, left button.
		'{8'hC9, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'h80, 1'b0, '0},
		// Middle button, negative Y motion moves the pointer down.
		'{8'h2C, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h9C, 1'b0, '0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [POS_W-1:0]       wr_data;

	pmt_byte_if mouse_bytes ();
	pmt_pos_if  pointer_out ();

	ps2_mouse_packet_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.rx_stream (mouse_bytes),
		.pointer   (pointer_out)
	);

	// Predictor state: tracked pointer, packet assembly and the clamp limits.
	logic [POS_W-1:0]    trk_x;
	logic [POS_W-1:0]    trk_y;
	logic [BUTTON_W-1:0] trk_btn;
	logic [BYTE_W-1:0]   trk_hdr;
	logic [BYTE_W-1:0]   trk_xbyte;
	byte_phase_t         trk_phase;
	logic [POS_W-1:0]    lim_x;
	logic [POS_W-1:0]    lim_y;

	pointer_t pending_moves [$];
	int       errors;
	int       src_idle_pct;
	int       bytes_sent;
	bit       idling;
	bit       hold_off_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog.
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	// Share of cycles spent idle; re-picked now and then so that calm stretches occur.
	function automatic int idle_share();
		int pick;
		if (!idling)
			return 0;
		pick = $urandom_range(0, 2);
		return (pick == 0) ? 0 : (pick == 1) ? 8 : 30;
	endfunction

	// Advance the packet tracker by one byte. Returns 1 when the byte closes a packet
	// with the sync bit set, with the new pointer in moved.
	function automatic bit track_byte(input logic [BYTE_W-1:0] b, output pointer_t moved);
		logic signed [8:0] dx;
		logic signed [8:0] dy;
		int nx;
		int ny;
		moved = '0;
		if (trk_phase == PH_HEADER) begin
			trk_hdr   = b;
			trk_phase = PH_XBYTE;
			return 1'b0;
		end
		if (trk_phase == PH_XBYTE) begin
			trk_xbyte = b;
			trk_phase = PH_YBYTE;
			return 1'b0;
		end
		trk_phase = PH_HEADER;
		if (!trk_hdr[SYNC_BIT])
			return 1'b0;
		trk_btn = trk_hdr[BUTTON_W-1:0];
		dx = {trk_hdr[X_SIGN_BIT], trk_xbyte};
		dy = {trk_hdr[Y_SIGN_BIT], b};
		nx = int'(trk_x);
		nx += dx;
		ny = int'(trk_y);
		ny -= dy;
		// Clamp each axis to 0..limit.
		if (nx < 0)
			trk_x = '0;
		else if (nx > int'(lim_x))
			trk_x = lim_x;
		else
			trk_x = nx[POS_W-1:0];
		if (ny < 0)
			trk_y = '0;
		else if (ny > int'(lim_y))
			trk_y = lim_y;
		else
			trk_y = ny[POS_W-1:0];
		moved = '{x: trk_x, y: trk_y, btn: trk_btn};
		return 1'b1;
	endfunction

	// Offer one byte, wait for the request to be taken and record what it should cause.
	// Returns at the accepting edge with valid still high.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
			input pointer_t want = '0);
		pointer_t moved;
		if (bytes_sent % 50 == 0)
			src_idle_pct = idle_share();
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			mouse_bytes.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		mouse_bytes.valid   <= 1'b1;
		mouse_bytes.rx_byte <= b;
		@(posedge clk);
		while (!mouse_bytes.ready)
			@(posedge clk);
		bytes_sent++;
		if (track_byte(b, moved))
			pending_moves.push_back(typed ? want : moved);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [POS_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MAX_X: lim_x = val;
			REG_MAX_Y: lim_y = val;
			default: ;
		endcase
	endtask

	// Finish the open packet, stop offering bytes and let every result come out.
	task automatic settle();
		while (trk_phase != PH_HEADER)
			send_byte(8'($urandom_range(0, 255)));
		mouse_bytes.valid <= 1'b0;
		while (pending_moves.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Signed 9-bit motion: half the time a small step, otherwise anything.
	function automatic logic [8:0] motion();
		if ($urandom_range(0, 1) == 0)
			return 9'($signed($urandom_range(0, 15)) - 8);
		return 9'($urandom_range(0, 511));
	endfunction

	// One setting of the limits followed by a run of random packets and stray bytes.
	task automatic run_phase(input logic [POS_W-1:0] new_x, input logic [POS_W-1:0] new_y);
		int sent;
		int kind;
		logic [BYTE_W-1:0] hdr;
		logic [8:0] dx;
		logic [8:0] dy;
		write_reg(REG_MAX_X, new_x);
		write_reg(REG_MAX_Y, new_y);
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
			12'($urandom_range(0, 4095)));
		sent = 0;
		while (sent < PHASE_BYTES) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				// A stray byte knocks the packet framing out of step.
				send_byte(8'($urandom_range(0, 255)));
				sent++;
			end else begin
				while (trk_phase != PH_HEADER) begin
					send_byte(8'($urandom_range(0, 255)));
					sent++;
				end
				hdr = 8'($urandom_range(0, 255));
				dx  = motion();
				dy  = motion();
				hdr[SYNC_BIT]   = (kind >= 20);
				hdr[X_SIGN_BIT] = dx[8];
				hdr[Y_SIGN_BIT] = dy[8];
				send_byte(hdr);
				send_byte(dx[7:0]);
				send_byte(dy[7:0]);
				sent += 3;
			end
		end
		settle();
	endtask

	// Result side: random stalls, and one long hold-off on request.
	initial begin
		int held;
		int sink_idle_pct;
		int turns;
		pointer_out.ready <= 1'b0;
		sink_idle_pct = 0;
		turns = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (turns % 50 == 0)
				sink_idle_pct = idle_share();
			turns++;
			if (hold_off_req) begin
				pointer_out.ready <= 1'b0;
				for (held = 0; held < HOLD_OFF_CYCLES; held++)
					@(posedge clk);
				hold_off_req = 1'b0;
			end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
				pointer_out.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			pointer_out.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Compare each taken result with the oldest expected pointer.
	always @(posedge clk) begin
		pointer_t want;
		if (arst_n && pointer_out.valid && pointer_out.ready) begin
			if (pending_moves.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d buttons=%0d", $realtime,
					pointer_out.pos_x, pointer_out.pos_y, pointer_out.button_bits);
				errors++;
			end else begin
				want = pending_moves.pop_front();
				if (pointer_out.pos_x !== want.x) begin
					$display("%0t: pos_x expected %0d got %0d", $realtime, want.x,
						pointer_out.pos_x);
					errors++;
				end
				if (pointer_out.pos_y !== want.y) begin
					$display("%0t: pos_y expected %0d got %0d", $realtime, want.y,
						pointer_out.pos_y);
					errors++;
				end
				if (pointer_out.button_bits !== want.btn) begin
					$display("%0t: button_bits expected %0d got %0d", $realtime, want.btn,
						pointer_out.button_bits);
					errors++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n              <= 1'b0;
		wr_en               <= 1'b0;
		wr_index            <= REG_MAX_X;
		wr_data             <= '0;
		mouse_bytes.valid   <= 1'b0;
		mouse_bytes.rx_byte <= '0;
		trk_x        = '0;
		trk_y        = '0;
		trk_btn      = '0;
		trk_hdr      = '0;
		trk_xbyte    = '0;
		trk_phase    = PH_HEADER;
		lim_x        = MAX_X_RESET;
		lim_y        = MAX_Y_RESET;
		errors       = 0;
		bytes_sent   = 0;
		idling       = 1'b1;
		hold_off_req = 1'b0;
		src_idle_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].want);
		settle();

		run_phase('0, '0);
		run_phase(12'd4095, 12'd4095);
		hold_off_req = 1'b1;
		run_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
		run_phase(12'd1, 12'd4095);
		run_phase(12'd4095, 12'd1);
		run_phase(12'($urandom_range(0, 63)), 12'($urandom_range(0, 63)));
		idling = 1'b0;
		run_phase(MAX_X_RESET, MAX_Y_RESET);

		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
